// ----- src/rph_pkg.sv -----
// Shared types, constants and helper functions for the ray and plane hit block.
package rph_pkg;

  localparam int COORD_W             = 32;
  localparam int NORM_W              = 16;
  localparam int EPS_W               = 16;
  localparam int LAMBDA_W            = 31;
  localparam int TEX_W               = 16;
  localparam int AXIS_W              = 32;
  localparam int WIDE_W              = 64;
  localparam int NORM_FRAC           = 14;
  localparam int DOT_W               = 50;
  localparam int MAG_W               = 49;
  localparam int TEX_LSB             = 46;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int ADDR_W              = 5;
  localparam int MID_DEPTH           = 4;
  localparam int OUT_DEPTH           = 2;

  localparam logic [2:0] REG_NORMAL_X  = 3'd0;
  localparam logic [2:0] REG_NORMAL_Y  = 3'd1;
  localparam logic [2:0] REG_NORMAL_Z  = 3'd2;
  localparam logic [2:0] REG_OFFSET    = 3'd3;
  localparam logic [2:0] REG_EPSILON   = 3'd4;
  localparam logic [2:0] REG_VISIBLE   = 3'd5;

  localparam logic [LAMBDA_W-1:0] LAMBDA_MAX = '1;
  // ten times 0.9 in Q1.14
  localparam logic [19:0] SEED_LIMIT = 20'd147456;

  typedef struct packed {
    logic                         busy;
    logic                         visible;
    logic [EPS_W-1:0]             eps;
    logic [COORD_W-1:0]           offset;
    logic [2:0][NORM_W-1:0]       normal;
    logic [2:0][AXIS_W-1:0]       ua;
    logic [2:0][AXIS_W-1:0]       va;
    logic [2:0][WIDE_W-1:0]       org;
  } cfg_t;

  typedef struct packed {
    logic                         miss;
    logic [MAG_W-1:0]             num_mag;
    logic [MAG_W-1:0]             den_mag;
    logic [2:0][COORD_W-1:0]      pos;
    logic [2:0][COORD_W-1:0]      dir;
  } ray_t;

  typedef struct packed {
    logic                         hit;
    logic [LAMBDA_W-1:0]          distance;
    logic [TEX_W-1:0]             tex_u;
    logic [TEX_W-1:0]             tex_v;
  } res_t;

  function automatic logic [WIDE_W-1:0] to_q32(logic signed [WIDE_W-1:0] x, int k);
    if (k > 32) to_q32 = WIDE_W'(x >>> (k - 32));
    else to_q32 = x << (32 - k);
  endfunction

  function automatic logic [MAG_W-1:0] mag_dot(logic signed [DOT_W-1:0] x);
    mag_dot = x[DOT_W-1] ? MAG_W'(-x) : MAG_W'(x);
  endfunction

endpackage

// ----- src/rph_fifo.sv -----
// Small register queue with occupancy count.
module rph_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q, wr_d, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop) rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

// ----- src/rph_cfg.sv -----
// Register file and texture axis sequencer (square root and serial divide).
module rph_cfg #(
  parameter int COORD_FRAC_BITS = rph_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rph_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output rph_pkg::cfg_t             cfg_o
);
  import rph_pkg::*;

  localparam logic [2:0] ST_UPREP  = 3'd0;
  localparam logic [2:0] ST_SQRT   = 3'd1;
  localparam logic [2:0] ST_DLOAD  = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_VCROSS = 3'd4;
  localparam logic [2:0] ST_VSQ    = 3'd5;
  localparam logic [2:0] ST_IDLE   = 3'd6;

  localparam logic [WIDE_W-1:0] SQ_BIT0 = WIDE_W'(1) << 62;

  logic signed [NORM_W-1:0]  nrm_q [3];
  logic signed [COORD_W-1:0] off_q;
  logic [EPS_W-1:0]          eps_q;
  logic                      vis_q;

  logic [2:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       vph_q, vph_d;

  logic signed [16:0]        uc_q [3];
  logic signed [32:0]        vc_q [3];
  logic signed [AXIS_W-1:0]  ua_q [3];
  logic signed [AXIS_W-1:0]  va_q [3];
  logic [WIDE_W-1:0]         org_q [3];
  logic [WIDE_W-1:0]         sqx_q, sqr_q, sqb_q, acc_q;
  logic [WIDE_W-1:0]         dnum_q, dquo_q;
  logic [31:0]               drem_q;
  logic                      dneg_q;

  logic        wr;
  logic [2:0]  widx;
  logic signed [16:0] nx, ny, nz, c0, c1, c2;
  logic [16:0] m0, m1, m2, axm;
  logic [34:0] s2;
  logic [WIDE_W-1:0] sq_sum;
  logic [32:0] rem_sh;
  logic        ge;
  logic [WIDE_W-1:0] qfin;
  logic [AXIS_W-1:0] qres;
  logic signed [47:0] pa, pb;
  logic signed [48:0] vdf;
  logic signed [15:0] na, nb;
  logic signed [AXIS_W-1:0] ub, ud;
  logic [32:0] vm_sel;
  logic [16:0] um_sel;
  logic [65:0] vsq;
  logic signed [47:0] nd [3];

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = paddr[ADDR_W-1:2];

  always_comb begin
    case (widx)
      REG_NORMAL_X: prdata = 32'(unsigned'(nrm_q[0]));
      REG_NORMAL_Y: prdata = 32'(unsigned'(nrm_q[1]));
      REG_NORMAL_Z: prdata = 32'(unsigned'(nrm_q[2]));
      REG_OFFSET:   prdata = off_q;
      REG_EPSILON:  prdata = 32'(eps_q);
      REG_VISIBLE:  prdata = 32'(vis_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q[0] <= '0;
      nrm_q[1] <= '0;
      nrm_q[2] <= 16'sd16384;
      off_q    <= '0;
      eps_q    <= 16'd7;
      vis_q    <= 1'b1;
    end else if (wr) begin
      case (widx)
        REG_NORMAL_X: nrm_q[0] <= pwdata[15:0];
        REG_NORMAL_Y: nrm_q[1] <= pwdata[15:0];
        REG_NORMAL_Z: nrm_q[2] <= pwdata[15:0];
        REG_OFFSET:   off_q    <= pwdata;
        REG_EPSILON:  eps_q    <= pwdata[15:0];
        REG_VISIBLE:  vis_q    <= pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    nx  = {nrm_q[0][15], nrm_q[0]};
    ny  = {nrm_q[1][15], nrm_q[1]};
    nz  = {nrm_q[2][15], nrm_q[2]};
    axm = nx[16] ? -nx : nx;
    if (20'(axm) * 20'd10 > SEED_LIMIT) begin
      c0 = -nz;
      c1 = '0;
      c2 = nx;
    end else begin
      c0 = '0;
      c1 = nz;
      c2 = -ny;
    end
    m0 = c0[16] ? -c0 : c0;
    m1 = c1[16] ? -c1 : c1;
    m2 = c2[16] ? -c2 : c2;
    s2 = 35'(m0) * 35'(m0) + 35'(m1) * 35'(m1) + 35'(m2) * 35'(m2);
    for (int i = 0; i < 3; i++) nd[i] = nrm_q[i] * off_q;
  end

  always_comb begin
    sq_sum = sqr_q + sqb_q;
    rem_sh = {drem_q, dnum_q[WIDE_W-1]};
    ge     = rem_sh >= {1'b0, sqr_q[31:0]};
    qfin   = {dquo_q[WIDE_W-2:0], ge};
    if (sqr_q[31:0] == '0) qres = '0;
    else qres = dneg_q ? -qfin[AXIS_W-1:0] : qfin[AXIS_W-1:0];
    case (idx_q)
      2'd0: begin
        na = nrm_q[1]; ub = ua_q[2]; nb = nrm_q[2]; ud = ua_q[1];
      end
      2'd1: begin
        na = nrm_q[2]; ub = ua_q[0]; nb = nrm_q[0]; ud = ua_q[2];
      end
      default: begin
        na = nrm_q[0]; ub = ua_q[1]; nb = nrm_q[1]; ud = ua_q[0];
      end
    endcase
    pa     = na * ub;
    pb     = nb * ud;
    vdf    = 49'(pa) - 49'(pb);
    vm_sel = vc_q[idx_q][32] ? 33'(-vc_q[idx_q]) : 33'(vc_q[idx_q]);
    um_sel = uc_q[idx_q][16] ? 17'(-uc_q[idx_q]) : 17'(uc_q[idx_q]);
    vsq    = 66'(vm_sel) * 66'(vm_sel);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    vph_d   = vph_q;
    case (state_q)
      ST_UPREP: begin
        state_d = ST_SQRT;
        cnt_d   = '0;
        vph_d   = 1'b0;
      end
      ST_SQRT: begin
        if (cnt_q == 6'd31) begin
          cnt_d   = '0;
          idx_d   = '0;
          state_d = ST_DLOAD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DLOAD: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == 6'd63) begin
          if (idx_q == 2'd2) begin
            idx_d   = '0;
            state_d = vph_q ? ST_IDLE : ST_VCROSS;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_DLOAD;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_VCROSS: begin
        if (idx_q == 2'd2) begin
          idx_d   = '0;
          state_d = ST_VSQ;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_VSQ: begin
        if (idx_q == 2'd2) begin
          cnt_d   = '0;
          vph_d   = 1'b1;
          state_d = ST_SQRT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_IDLE: ;
      default: state_d = ST_IDLE;
    endcase
    if (wr && widx <= REG_VISIBLE) state_d = ST_UPREP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_UPREP;
      cnt_q   <= '0;
      idx_q   <= '0;
      vph_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      vph_q   <= vph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_UPREP: begin
        uc_q[0] <= c0;
        uc_q[1] <= c1;
        uc_q[2] <= c2;
        sqx_q   <= {s2[31:0], 32'b0};
        sqr_q   <= '0;
        sqb_q   <= SQ_BIT0;
        for (int i = 0; i < 3; i++) begin
          org_q[i] <= to_q32(-(WIDE_W'(nd[i])), COORD_FRAC_BITS + NORM_FRAC);
        end
      end
      ST_SQRT: begin
        if (sqx_q >= sq_sum) begin
          sqx_q <= sqx_q - sq_sum;
          sqr_q <= (sqr_q >> 1) + sqb_q;
        end else begin
          sqr_q <= sqr_q >> 1;
        end
        sqb_q <= sqb_q >> 2;
      end
      ST_DLOAD: begin
        drem_q <= '0;
        dquo_q <= '0;
        if (vph_q) begin
          dnum_q <= WIDE_W'(vm_sel) << 30;
          dneg_q <= vc_q[idx_q][32];
        end else begin
          dnum_q <= WIDE_W'(um_sel) << 46;
          dneg_q <= uc_q[idx_q][16];
        end
      end
      ST_DIV: begin
        drem_q <= ge ? 32'(rem_sh - {1'b0, sqr_q[31:0]}) : rem_sh[31:0];
        dquo_q <= qfin;
        dnum_q <= dnum_q << 1;
        if (cnt_q == 6'd63) begin
          if (vph_q) va_q[idx_q] <= qres;
          else ua_q[idx_q] <= qres;
        end
      end
      ST_VCROSS: begin
        vc_q[idx_q] <= vdf[48:16];
        acc_q       <= '0;
      end
      ST_VSQ: begin
        acc_q <= acc_q + vsq[WIDE_W-1:0];
        if (idx_q == 2'd2) begin
          sqx_q <= acc_q + vsq[WIDE_W-1:0];
          sqr_q <= '0;
          sqb_q <= SQ_BIT0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cfg_o.busy    = (state_q != ST_IDLE);
    cfg_o.visible = vis_q;
    cfg_o.eps     = eps_q;
    cfg_o.offset  = off_q;
    for (int i = 0; i < 3; i++) begin
      cfg_o.normal[i] = nrm_q[i];
      cfg_o.ua[i]     = ua_q[i];
      cfg_o.va[i]     = va_q[i];
      cfg_o.org[i]    = org_q[i];
    end
  end

endmodule

// ----- src/rph_front.sv -----
// Front stages: plane dot products, miss classification and admission control.
module rph_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rph_pkg::cfg_t                        cfg_i,
  input  logic                                 push_i,
  input  logic [2:0][rph_pkg::COORD_W-1:0]     pos_i,
  input  logic [2:0][rph_pkg::COORD_W-1:0]     dir_i,
  input  logic [$clog2(rph_pkg::MID_DEPTH+1)-1:0] mid_count_i,
  output logic                                 full_o,
  output logic                                 mid_push_o,
  output rph_pkg::ray_t                        mid_o
);
  import rph_pkg::*;

  localparam int CNT_W = $clog2(MID_DEPTH + 1);

  logic                        v1_q, v2_q;
  logic signed [47:0]          np_q [3];
  logic signed [47:0]          nv_q [3];
  logic [2:0][COORD_W-1:0]     p1_q, d1_q;
  ray_t                        ray_q;
  logic signed [DOT_W-1:0]     den, num;
  logic [MAG_W-1:0]            den_mag, num_mag;
  logic                        miss;
  logic [CNT_W+1:0]            load;

  assign load   = (CNT_W + 2)'(mid_count_i) + (CNT_W + 2)'(v1_q) + (CNT_W + 2)'(v2_q);
  assign full_o = cfg_i.busy || (load >= (CNT_W + 2)'(MID_DEPTH));

  always_comb begin
    den = '0;
    num = DOT_W'($signed(cfg_i.offset)) <<< NORM_FRAC;
    for (int i = 0; i < 3; i++) begin
      den = den + DOT_W'(nv_q[i]);
      num = num + DOT_W'(np_q[i]);
    end
    den_mag = mag_dot(den);
    num_mag = mag_dot(num);
    miss = !cfg_i.visible || (den == '0) ||
           (den_mag < MAG_W'({cfg_i.eps, {NORM_FRAC{1'b0}}})) ||
           ((num != '0) && (num[DOT_W-1] == den[DOT_W-1]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= push_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      np_q[i] <= $signed(cfg_i.normal[i]) * $signed(pos_i[i]);
      nv_q[i] <= $signed(cfg_i.normal[i]) * $signed(dir_i[i]);
    end
    p1_q          <= pos_i;
    d1_q          <= dir_i;
    ray_q.miss    <= miss;
    ray_q.num_mag <= num_mag;
    ray_q.den_mag <= den_mag;
    ray_q.pos     <= p1_q;
    ray_q.dir     <= d1_q;
  end

  assign mid_push_o = v2_q;
  assign mid_o      = ray_q;

endmodule

// ----- src/rph_back.sv -----
// Back pipeline: distance divider, hit point and texture coordinate dot products.
module rph_back #(
  parameter int COORD_FRAC_BITS = rph_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rph_pkg::cfg_t cfg_i,
  input  rph_pkg::ray_t mid_i,
  input  logic          mid_empty_i,
  output logic          mid_pop_o,
  input  logic          out_full_i,
  output logic          out_push_o,
  output rph_pkg::res_t out_o
);
  import rph_pkg::*;

  localparam int QS = LAMBDA_W;
  localparam int RW = MAG_W + COORD_FRAC_BITS + QS;

  logic en;

  logic                    v_q    [QS+1];
  logic [RW-1:0]           rem_q  [QS+1];
  logic [LAMBDA_W-1:0]     quo_q  [QS+1];
  logic [MAG_W-1:0]        b_q    [QS+1];
  logic                    sat_q  [QS+1];
  logic                    miss_q [QS+1];
  logic [2:0][COORD_W-1:0] pos_q  [QS+1];
  logic [2:0][COORD_W-1:0] dir_q  [QS+1];

  logic [RW-1:0]           rem0;

  assign en        = !out_full_i;
  assign mid_pop_o = en && !mid_empty_i;
  assign rem0      = RW'(mid_i.num_mag) << COORD_FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (en) v_q[0] <= mid_pop_o;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0]  <= rem0;
      quo_q[0]  <= '0;
      b_q[0]    <= mid_i.den_mag;
      sat_q[0]  <= rem0 >= (RW'(mid_i.den_mag) << QS);
      miss_q[0] <= mid_i.miss;
      pos_q[0]  <= mid_i.pos;
      dir_q[0]  <= mid_i.dir;
    end
  end

  for (genvar s = 1; s <= QS; s++) begin : g_div
    localparam int K = QS - s;
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(b_q[s-1]) << K;
    assign ge  = rem_q[s-1] >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[s] <= 1'b0;
      else if (en) v_q[s] <= v_q[s-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[s]    <= ge ? rem_q[s-1] - dsh : rem_q[s-1];
        quo_q[s]    <= quo_q[s-1] | (LAMBDA_W'(ge) << K);
        b_q[s]      <= b_q[s-1];
        sat_q[s]    <= sat_q[s-1];
        miss_q[s]   <= miss_q[s-1];
        pos_q[s]    <= pos_q[s-1];
        dir_q[s]    <= dir_q[s-1];
      end
    end
  end

  logic                  vh_q, vm_q, vs_q, va_q;
  logic                  mh_q, mm_q, ms_q;
  logic [LAMBDA_W-1:0]   lh_q, lm_q, ls_q;
  logic [WIDE_W-1:0]     rel_q [3];
  logic [WIDE_W-1:0]     plu_q [3], plv_q [3];
  logic [31:0]           phu_q [3], phv_q [3];
  logic [WIDE_W-1:0]     tu_q [3], tv_q [3];
  res_t                  res_q;

  logic [LAMBDA_W-1:0]   lam;
  logic signed [WIDE_W-1:0] ld [3];
  logic signed [WIDE_W-1:0] hp [3];
  logic signed [WIDE_W:0]   pu [3], pv [3];
  logic [WIDE_W-1:0]     hu [3], hv [3];
  logic [WIDE_W-1:0]     su, sv;

  always_comb begin
    lam = sat_q[QS] ? LAMBDA_MAX : quo_q[QS];
    su  = '0;
    sv  = '0;
    for (int i = 0; i < 3; i++) begin
      ld[i] = $signed({1'b0, lam}) * $signed(dir_q[QS][i]);
      hp[i] = (WIDE_W'($signed(pos_q[QS][i])) <<< COORD_FRAC_BITS) + ld[i];
      pu[i] = $signed({1'b0, rel_q[i][31:0]}) * $signed(cfg_i.ua[i]);
      pv[i] = $signed({1'b0, rel_q[i][31:0]}) * $signed(cfg_i.va[i]);
      hu[i] = rel_q[i][63:32] * cfg_i.ua[i];
      hv[i] = rel_q[i][63:32] * cfg_i.va[i];
      su    = su + tu_q[i];
      sv    = sv + tv_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
      vm_q <= 1'b0;
      vs_q <= 1'b0;
      va_q <= 1'b0;
    end else if (en) begin
      vh_q <= v_q[QS];
      vm_q <= vh_q;
      vs_q <= vm_q;
      va_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mh_q <= miss_q[QS];
      lh_q <= lam;
      mm_q <= mh_q;
      lm_q <= lh_q;
      ms_q <= mm_q;
      ls_q <= lm_q;
      for (int i = 0; i < 3; i++) begin
        rel_q[i] <= to_q32(hp[i], 2 * COORD_FRAC_BITS) - cfg_i.org[i];
        plu_q[i] <= pu[i][WIDE_W-1:0];
        plv_q[i] <= pv[i][WIDE_W-1:0];
        phu_q[i] <= hu[i][31:0];
        phv_q[i] <= hv[i][31:0];
        tu_q[i]  <= plu_q[i] + {phu_q[i], 32'b0};
        tv_q[i]  <= plv_q[i] + {phv_q[i], 32'b0};
      end
      res_q.hit      <= !ms_q;
      res_q.distance <= ms_q ? '0 : ls_q;
      res_q.tex_u    <= ms_q ? '0 : su[TEX_LSB+TEX_W-1:TEX_LSB];
      res_q.tex_v    <= ms_q ? '0 : sv[TEX_LSB+TEX_W-1:TEX_LSB];
    end
  end

  assign out_push_o = en && va_q;
  assign out_o      = res_q;

endmodule

// ----- src/ray_plane_hit_and_texcoord.sv -----
// Top level of the ray and plane intersection block with planar texture coordinates.
// Usage:
//   Rays enter through a queue-style port: an origin and direction are taken when
//   push is high and full is low. Results leave the same way: while empty is low the
//   oldest result (hit, distance, tex_u, tex_v) is on the outputs and is taken when
//   pop is high. The plane is set through the APB-style port while no ray is in flight.
// Throughput: one ray per cycle while full is low. Each ray passes the front dot
//   products, the queue, the 31-stage distance divider and the texture dot products.
// Configuration: every write to one of the six registers restarts the texture axis
//   sequencer (two 32-step square roots and six 64-step serial divides); full
//   stays high meanwhile. Reset loads the register defaults and runs the same sequence.
// Stalls: a stalled receiver freezes the back pipeline; the front keeps accepting
//   until the queue between the two parts has no room, then raises full.
module ray_plane_hit_and_texcoord #(
  parameter int COORD_FRAC_BITS = rph_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic signed [31:0]          origin_x_i,
  input  logic signed [31:0]          origin_y_i,
  input  logic signed [31:0]          origin_z_i,
  input  logic signed [31:0]          dir_x_i,
  input  logic signed [31:0]          dir_y_i,
  input  logic signed [31:0]          dir_z_i,
  output logic                        empty,
  input  logic                        pop,
  output logic                        hit_o,
  output logic [30:0]                 hit_distance_o,
  output logic [15:0]                 tex_u_o,
  output logic [15:0]                 tex_v_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rph_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rph_pkg::*;

  cfg_t                        cfg;
  ray_t                        mid_in, mid_out;
  res_t                        res_in, res_out;
  logic                        acc, mid_push, mid_pop, mid_empty, mid_full;
  logic                        out_push, out_full;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
  logic [2:0][COORD_W-1:0]     pos, dir;

  assign acc = push && !full;
  assign pos = {origin_z_i, origin_y_i, origin_x_i};
  assign dir = {dir_z_i, dir_y_i, dir_x_i};

  rph_cfg #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  rph_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg), .push_i(acc), .pos_i(pos), .dir_i(dir),
    .mid_count_i(mid_count), .full_o(full), .mid_push_o(mid_push), .mid_o(mid_in)
  );

  rph_fifo #(.WIDTH($bits(ray_t)), .DEPTH(MID_DEPTH)) u_mid (
    .clk_i, .rst_ni, .push_i(mid_push), .data_i(mid_in), .pop_i(mid_pop),
    .data_o(mid_out), .empty_o(mid_empty), .full_o(mid_full), .count_o(mid_count)
  );

  rph_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .mid_i(mid_out), .mid_empty_i(mid_empty || mid_full && 1'b0),
    .mid_pop_o(mid_pop), .out_full_i(out_full), .out_push_o(out_push), .out_o(res_in)
  );

  rph_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out (
    .clk_i, .rst_ni, .push_i(out_push), .data_i(res_in), .pop_i(pop),
    .data_o(res_out), .empty_o(empty), .full_o(out_full), .count_o(out_count)
  );

  assign hit_o          = res_out.hit && (out_count != '0);
  assign hit_distance_o = res_out.distance;
  assign tex_u_o        = res_out.tex_u;
  assign tex_v_o        = res_out.tex_v;

endmodule

// ----- src/rph_checker.sv -----
// Port-level assertions for the ray and plane hit block, bound to the top level.
module rph_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic                       hit_o,
  input logic [30:0]                hit_distance_o,
  input logic [15:0]                tex_u_o,
  input logic [15:0]                tex_v_o,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [rph_pkg::ADDR_W-1:0] paddr
);
  import rph_pkg::*;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !hit_o) |-> (hit_distance_o == '0 && tex_u_o == '0 && tex_v_o == '0))
    else $error("miss result carries nonzero fields");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(hit_o) && $stable(hit_distance_o) &&
                          $stable(tex_u_o) && $stable(tex_v_o)))
    else $error("stalled result changed");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr[ADDR_W-1:2] <= REG_VISIBLE) |=> full)
    else $error("register write did not block new requests");

endmodule

bind ray_plane_hit_and_texcoord rph_checker u_rph_checker (
  .clk_i, .rst_ni, .full, .empty, .pop, .hit_o, .hit_distance_o, .tex_u_o, .tex_v_o,
  .psel, .penable, .pwrite, .paddr
);
